>>> rtl/ebu_pkg.sv
// Package with the shared types and constants of the escaped bit unpacker.
`default_nettype none

package ebu_pkg;

  // Decoder modes.
  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_ESCAPE  = 2'd1,
    MODE_PARTIAL = 2'd2,
    MODE_ENDED   = 2'd3
  } mode_t;

  // Register map and bus widths.
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;
  localparam logic        REG_DELIM  = 1'b0;

  // Stream constants.
  localparam logic [7:0] DELIM_RESET = 8'h40;
  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_ONE   = 8'h31;
  localparam logic [7:0] DIGIT_EIGHT = 8'h38;
  localparam logic [3:0] BYTE_BITS   = 4'd8;

endpackage

`default_nettype wire

>>> rtl/escaped_bit_unpacker_top.sv
// Top level of the escaped bit unpacker: byte decoder, bit shifter and register port.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_stall   in_byte[7:0]
//   result    out        out_valid/out_stall bit_value
//   config    in         APB psel/penable    paddr/pwdata/prdata
//
// A byte is decoded as it is accepted and loaded into a bit shifter that hands
// one bit per cycle to the result register while the result is not stalled;
// the next byte is taken as the last bit moves out, or at once after a byte
// that yields no bits. Synchronous reset empties
// the shifter and result register, selects normal mode and restores the '@'
// delimiter. A stalled result holds its bit; the input stalls while bits remain.
`default_nettype none

module escaped_bit_unpacker_top (
  input  wire                        clk,
  input  wire                        rst,
  // Configuration port
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [ebu_pkg::ADDR_W-1:0]  paddr,
  input  wire [ebu_pkg::DATA_W-1:0]  pwdata,
  output logic [ebu_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // Input byte channel
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [7:0]                  in_byte,
  // Result bit channel
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic                       bit_value
);

  import ebu_pkg::*;

  logic [7:0] delimiter_byte;
  mode_t      mode, mode_next;
  logic [3:0] final_bit_count, final_bit_count_next;
  logic [7:0] work_data;
  logic [3:0] work_cnt;
  logic [7:0] emit_data;
  logic [3:0] emit_cnt;
  logic [3:0] part_cnt;
  logic       out_free;
  logic       move;
  logic       in_take;
  logic       cfg_write;

  // Register port: always ready, one register at word address zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DELIM);
  assign prdata    = (paddr[2] == REG_DELIM) ? {24'd0, delimiter_byte} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_byte <= DELIM_RESET;
    end else if (cfg_write) begin
      delimiter_byte <= pwdata[7:0];
    end
  end

  // Handshake: the shifter drains into the result register when it is free.
  assign out_free = !out_valid || !out_stall;
  assign move     = out_free && (work_cnt != 4'd0);
  assign in_stall = (work_cnt != 4'd0) && !(move && (work_cnt == 4'd1));
  assign in_take  = in_valid && !in_stall;

  // Count of a partial byte, clamped to a full byte.
  assign part_cnt = (final_bit_count > BYTE_BITS) ? BYTE_BITS : final_bit_count;

  // Byte decoder: next mode and the bits to emit, left aligned.
  always_comb begin
    mode_next            = mode;
    final_bit_count_next = final_bit_count;
    emit_data            = 8'd0;
    emit_cnt             = 4'd0;
    if (in_take) begin
      unique case (mode)
        MODE_NORMAL: begin
          if (in_byte == delimiter_byte) begin
            mode_next = MODE_ESCAPE;
          end else begin
            emit_data = in_byte;
            emit_cnt  = BYTE_BITS;
          end
        end
        MODE_ESCAPE: begin
          if (in_byte == delimiter_byte) begin
            mode_next = MODE_NORMAL;
            emit_data = delimiter_byte;
            emit_cnt  = BYTE_BITS;
          end else if (in_byte == DIGIT_ZERO) begin
            mode_next            = MODE_ENDED;
            final_bit_count_next = 4'd0;
          end else if (in_byte >= DIGIT_ONE && in_byte <= DIGIT_EIGHT) begin
            mode_next            = MODE_PARTIAL;
            final_bit_count_next = in_byte[3:0];
          end else begin
            mode_next = MODE_NORMAL;
          end
        end
        MODE_PARTIAL: begin
          mode_next            = MODE_NORMAL;
          final_bit_count_next = 4'd0;
          emit_data            = in_byte << (BYTE_BITS - part_cnt);
          emit_cnt             = part_cnt;
        end
        MODE_ENDED: begin
          mode_next = MODE_ENDED;
        end
        default: begin
          mode_next = MODE_NORMAL;
        end
      endcase
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_NORMAL;
      final_bit_count <= 4'd0;
    end else begin
      mode            <= mode_next;
      final_bit_count <= final_bit_count_next;
    end
  end

  // Bit shifter: loaded on an accepted transaction, shifts once per bit sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      work_cnt <= 4'd0;
    end else if (in_take) begin
      work_cnt <= emit_cnt;
    end else if (move) begin
      work_cnt <= work_cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      work_data <= emit_data;
    end else if (move) begin
      work_data <= {work_data[6:0], 1'b0};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      bit_value <= work_data[7];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ebu_checker.sv
// Port checker for the escaped bit unpacker and its bind to the top level.
`default_nettype none

module ebu_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        psel,
  input wire                        penable,
  input wire                        pwrite,
  input wire [ebu_pkg::ADDR_W-1:0]  paddr,
  input wire [ebu_pkg::DATA_W-1:0]  pwdata,
  input wire [ebu_pkg::DATA_W-1:0]  prdata,
  input wire                        pready,
  input wire                        in_stall,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire                        bit_value
);

  // A stalled result bit stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bit_value))
    else $error("stalled result transaction changed");

  // Reset leaves no result pending and the input open.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

  // A stalled input means bits are pending, so a result is offered next.
  a_stall_bits: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> out_valid)
    else $error("input stalled with no result following");

  // A delimiter write reads back on the following cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
      |-> prdata[7:0] == $past(pwdata[7:0]) && prdata[31:8] == 24'd0)
    else $error("delimiter register read back wrong");

endmodule

bind escaped_bit_unpacker_top ebu_checker u_ebu_checker (.*);

`default_nettype wire

>>> sim/escaped_bit_unpacker_top_tb.sv
// Self-checking testbench for the escaped bit unpacker: byte stimulus, bit prediction, checks.
`default_nettype none

module escaped_bit_unpacker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebu_pkg::*;

  localparam logic [ADDR_W-1:0] DELIM_ADDR = ADDR_W'(4 * REG_DELIM);
  localparam int TX_IDLE_LOW   = 12;
  localparam int RX_IDLE_HIGH  = 51;
  localparam int PHASE_BYTES   = 80;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPORT_MAX    = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                bit_value;

  // Stimulus bytes still to be offered and decoded bits still to arrive.
  logic [7:0]          pending_bytes[$];
  logic                expected_bits[$];

  // Decoder shadow: delimiter setting, mode and announced partial bit count.
  logic [7:0]          delim_cfg = DELIM_RESET;
  mode_t               dec_mode = MODE_NORMAL;
  logic [3:0]          partial_count = '0;

  int                  tx_idle_pct = TX_IDLE_LOW;
  int                  rx_idle_pct = RX_IDLE_HIGH;
  int                  fail_count = 0;
  int                  quiet_cycles = 0;
  bit                  byte_taken = 1'b0;

  escaped_bit_unpacker_top u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bit_value (bit_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Counts a failure; only the first few are described.
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Queues the lowest count bits of a byte, most significant first.
  task automatic queue_bits(input logic [7:0] value, input int count);
    for (int k = count - 1; k >= 0; k--) begin
      expected_bits.push_back(value[k]);
    end
  endtask

  // Advances the decoder shadow by one accepted byte.
  task automatic decode_byte(input logic [7:0] b);
    case (dec_mode)
      MODE_NORMAL: begin
        if (b == delim_cfg) begin
          dec_mode = MODE_ESCAPE;
        end else begin
          queue_bits(b, BYTE_BITS);
        end
      end
      MODE_ESCAPE: begin
        if (b == delim_cfg) begin
          dec_mode = MODE_NORMAL;
          queue_bits(delim_cfg, BYTE_BITS);
        end else if (b == DIGIT_ZERO) begin
          dec_mode = MODE_ENDED;
          partial_count = '0;
        end else if (b >= DIGIT_ONE && b <= DIGIT_EIGHT) begin
          partial_count = 4'(b - DIGIT_ZERO);
          dec_mode = MODE_PARTIAL;
        end else begin
          dec_mode = MODE_NORMAL;
        end
      end
      MODE_PARTIAL: begin
        queue_bits(b, (partial_count > BYTE_BITS) ? BYTE_BITS : partial_count);
        dec_mode = MODE_NORMAL;
        partial_count = '0;
      end
      default: begin
      end
    endcase
  endtask

  // Monitor: checks each result transaction, predicts from each input one,
  // and stops the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      byte_taken = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_bits.size() == 0) begin
          note_failure($sformatf("unexpected bit %0b", bit_value));
        end else if (expected_bits[0] !== bit_value) begin
          note_failure($sformatf("bit mismatch: expected %0b, got %0b",
                                 expected_bits[0], bit_value));
          void'(expected_bits.pop_front());
        end else begin
          void'(expected_bits.pop_front());
        end
      end
      if (byte_taken) begin
        decode_byte(in_byte);
      end
      if (byte_taken || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("escaped_bit_unpacker_top_tb: FAIL");
        $finish;
      end
    end
  end

  // Driver: offers queued bytes with random gaps and stalls the result side.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_byte  <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Waits until every byte is taken and every bit has arrived, then lets the
  // block finish any byte that yields no bits.
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (pending_bytes.size() != 0 || in_valid || expected_bits.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the delimiter register and reads it back.
  task automatic write_delimiter(input logic [7:0] value);
    logic [DATA_W-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DELIM_ADDR;
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    delim_cfg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[7:0] !== value) begin
      note_failure($sformatf("delimiter readback: expected %02h, got %02h",
                             value, readback[7:0]));
    end
  endtask

  // Queues random well-formed escape sequences, with some bad escapes mixed in.
  task automatic add_sequences(input int n_bytes);
    int         pushed;
    int         pick;
    logic [7:0] b;
    pushed = 0;
    while (pushed < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // Plain data byte.
        do begin
          b = 8'($urandom_range(255));
        end while (b == delim_cfg);
        pending_bytes.push_back(b);
        pushed += 1;
      end else if (pick < 52) begin
        // Escaped delimiter, a literal delimiter byte.
        pending_bytes.push_back(delim_cfg);
        pending_bytes.push_back(delim_cfg);
        pushed += 2;
      end else if (pick < 85) begin
        // Partial byte with a random announced count and random content.
        do begin
          b = 8'(DIGIT_ONE + $urandom_range(7));
        end while (b == delim_cfg);
        pending_bytes.push_back(delim_cfg);
        pending_bytes.push_back(b);
        pending_bytes.push_back(8'($urandom_range(255)));
        pushed += 3;
      end else begin
        // Bad escape: neither the delimiter nor a digit from zero to eight follows it.
        do begin
          b = 8'($urandom_range(255));
        end while (b == delim_cfg || (b >= DIGIT_ZERO && b <= DIGIT_EIGHT));
        pending_bytes.push_back(delim_cfg);
        pending_bytes.push_back(b);
        pushed += 2;
      end
    end
  endtask

  initial begin
    logic [7:0] directed[] = '{
      8'h00, 8'hFF, 8'hA5, DIGIT_ZERO,
      DELIM_RESET, DELIM_RESET,
      DELIM_RESET, DIGIT_ONE, 8'hFF,
      DELIM_RESET, DIGIT_EIGHT, 8'h5A,
      DELIM_RESET, DIGIT_ZERO + 8'd3, 8'hF5,
      DELIM_RESET, 8'h5A, 8'h3C,
      DELIM_RESET, DIGIT_ZERO - 8'd1,
      DELIM_RESET, DIGIT_EIGHT + 8'd1
    };
    logic [7:0] phase_delims[] = '{8'h00, 8'hFF, DIGIT_ZERO + 8'd5, DIGIT_ZERO,
                                   8'($urandom_range(255)), DELIM_RESET};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed bytes under the reset delimiter.
    foreach (directed[i]) begin
      pending_bytes.push_back(directed[i]);
    end

    // Random phases: sender rarely idle first, then receiver rarely idle,
    // then no idling at all.
    foreach (phase_delims[p]) begin
      wait_idle();
      write_delimiter(phase_delims[p]);
      if (p < 2) begin
        tx_idle_pct = TX_IDLE_LOW;
        rx_idle_pct = RX_IDLE_HIGH;
      end else if (p < 4) begin
        tx_idle_pct = RX_IDLE_HIGH;
        rx_idle_pct = TX_IDLE_LOW;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      add_sequences(PHASE_BYTES);
    end

    // End marker; everything after it must be swallowed.
    pending_bytes.push_back(DELIM_RESET);
    pending_bytes.push_back(DIGIT_ZERO);
    pending_bytes.push_back(DELIM_RESET);
    pending_bytes.push_back(DELIM_RESET);
    pending_bytes.push_back(DIGIT_ONE);
    repeat (4) pending_bytes.push_back(8'($urandom_range(255)));
    wait_idle();

    if (fail_count == 0 && expected_bits.size() == 0) begin
      $display("escaped_bit_unpacker_top_tb: PASS");
    end else begin
      $display("escaped_bit_unpacker_top_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> escaped_bit_unpacker_top.f
rtl/ebu_pkg.sv
rtl/escaped_bit_unpacker_top.sv
rtl/ebu_checker.sv
sim/escaped_bit_unpacker_top_tb.sv
